FILE: rtl/core/vpf_pkg.sv
package vpf_pkg;

    // payload word count, clamped to the three words an item carries
    localparam int PAYLOAD_WORDS = 3;
    localparam int MAX_HELD      = 3;
    localparam int WORDS_EFF     = (PAYLOAD_WORDS < 1) ? 1 :
                                   ((PAYLOAD_WORDS > MAX_HELD) ? MAX_HELD : PAYLOAD_WORDS);
    localparam int PAY_BYTES     = 4 * WORDS_EFF;
    localparam int FRAME_BYTES   = 6 + PAY_BYTES;
    localparam int CNT_W         = (PAY_BYTES > 1) ? $clog2(PAY_BYTES) : 1;
    localparam int SHIFT_W       = 32 * MAX_HELD;

    localparam logic [7:0] LEN_BYTE          = 8'(PAY_BYTES);
    localparam logic [7:0] SYNC_FIRST_RESET  = 8'd65;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'd67;

    // configuration register indexes
    localparam logic CFG_HEADER_FIRST  = 1'b0;
    localparam logic CFG_HEADER_SECOND = 1'b1;

    // frame sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR1,
        ST_HDR2,
        ST_TYPE,
        ST_LEN,
        ST_PAY,
        ST_SUMA,
        ST_SUMB
    } t_state;

    // control from sequencer to checksum unit
    typedef struct packed {
        logic clear;
        logic add;
    } t_sum_ctl;

endpackage

FILE: rtl/core/vpf_fletcher.sv
module vpf_fletcher (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vpf_pkg::t_sum_ctl i_ctl,
    input  logic [7:0]        i_byte,
    output logic [7:0]        o_sum_a,
    output logic [7:0]        o_sum_b
);
    import vpf_pkg::*;

    logic [7:0] r_sum_a, n_sum_a;
    logic [7:0] r_sum_b, n_sum_b;

    // running pair, wraps modulo 256
    always_comb begin
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        if (i_ctl.clear) begin
            n_sum_a = 8'd0;
            n_sum_b = 8'd0;
        end else if (i_ctl.add) begin
            n_sum_a = r_sum_a + i_byte;
            n_sum_b = r_sum_b + n_sum_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a <= 8'd0;
            r_sum_b <= 8'd0;
        end else begin
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
    end

    assign o_sum_a = r_sum_a;
    assign o_sum_b = r_sum_b;

`ifndef NO_ASSERTIONS
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> (r_sum_a == 8'd0) && (r_sum_b == 8'd0))
        else $error("checksum pair not cleared");
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.clear && !i_ctl.add |=> $stable(r_sum_a) && $stable(r_sum_b))
        else $error("checksum pair moved without add");
    a_b_tracks_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.clear && i_ctl.add |=> r_sum_b == $past(r_sum_b) + r_sum_a)
        else $error("checksum b did not accumulate a");
`endif

endmodule

FILE: rtl/core/vector_packet_framer_unit.sv
// Frames each input transfer (type byte and three 32-bit words) as an 18-byte
// packet: two sync bytes, type, length 12, the twelve payload bytes with each
// word least significant byte first, then Fletcher checksum A and B over type,
// length and payload. One frame byte leaves per cycle through a registered
// output unless the output stalls; the payload words sit in a shift register
// that moves one byte per cycle unless the output stalls, and the next item is
// taken in the cycle the final checksum byte is emitted. Output stalls hold
// the sequencer in its current state. The sync bytes come from two
// configuration registers, reset to 'A' and 'C'.
module vector_packet_framer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_packet_type,
    input  logic [31:0] i_word_x,
    input  logic [31:0] i_word_y,
    input  logic [31:0] i_word_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte
);
    import vpf_pkg::*;

    t_state             r_state, n_state;
    logic [7:0]         r_hdr_first, r_hdr_second;
    logic [7:0]         r_type;
    logic [SHIFT_W-1:0] r_shift;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;

    logic       w_slot;
    logic       w_emit;
    logic [7:0] w_byte;
    logic       w_last;
    logic       w_pay_done;
    logic       w_in_xfer;
    t_sum_ctl   w_sum_ctl;
    logic [7:0] w_sum_a, w_sum_b;

    // output register free for a new byte this cycle
    assign w_slot     = !r_out_valid || i_out_ready;
    assign w_pay_done = (r_cnt == CNT_W'(PAY_BYTES - 1));
    assign o_in_ready = (r_state == ST_IDLE) || ((r_state == ST_SUMB) && w_slot);
    assign w_in_xfer  = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= SYNC_FIRST_RESET;
            r_hdr_second <= SYNC_SECOND_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEADER_FIRST:  r_hdr_first  <= i_cfg_data;
                CFG_HEADER_SECOND: r_hdr_second <= i_cfg_data;
                default:           r_hdr_first  <= r_hdr_first;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_in_xfer) n_state = ST_HDR1;
            ST_HDR1: if (w_slot) n_state = ST_HDR2;
            ST_HDR2: if (w_slot) n_state = ST_TYPE;
            ST_TYPE: if (w_slot) n_state = ST_LEN;
            ST_LEN:  if (w_slot) n_state = ST_PAY;
            ST_PAY:  if (w_slot && w_pay_done) n_state = ST_SUMA;
            ST_SUMA: if (w_slot) n_state = ST_SUMB;
            ST_SUMB: begin
                if (w_slot) n_state = w_in_xfer ? ST_HDR1 : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // byte selection and checksum control
    always_comb begin
        w_emit    = 1'b0;
        w_byte    = 8'd0;
        w_last    = 1'b0;
        w_sum_ctl = '0;
        unique case (r_state)
            ST_IDLE: ;
            ST_HDR1: begin w_emit = w_slot; w_byte = r_hdr_first;  end
            ST_HDR2: begin w_emit = w_slot; w_byte = r_hdr_second; end
            ST_TYPE: begin
                w_emit = w_slot; w_byte = r_type;        w_sum_ctl.add = w_slot;
            end
            ST_LEN: begin
                w_emit = w_slot; w_byte = LEN_BYTE;      w_sum_ctl.add = w_slot;
            end
            ST_PAY: begin
                w_emit = w_slot; w_byte = r_shift[7:0];  w_sum_ctl.add = w_slot;
            end
            ST_SUMA: begin w_emit = w_slot; w_byte = w_sum_a; end
            ST_SUMB: begin w_emit = w_slot; w_byte = w_sum_b; w_last = 1'b1; end
            default: ;
        endcase
        if (w_in_xfer) begin
            w_sum_ctl.clear = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_xfer) begin
                r_cnt <= '0;
            end else if ((r_state == ST_PAY) && w_slot) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload shift line and output data
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_type  <= i_packet_type;
            r_shift <= {i_word_z, i_word_y, i_word_x};
        end else if ((r_state == ST_PAY) && w_slot) begin
            r_shift <= {8'd0, r_shift[SHIFT_W-1:8]};
        end
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
        end
    end

    vpf_fletcher u_fletcher (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sum_ctl),
        .i_byte  (w_byte),
        .o_sum_a (w_sum_a),
        .o_sum_b (w_sum_b)
    );

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last_byte  = r_out_last;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_state == ST_HDR1)
        else $error("accepted item did not start a frame");
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> (r_state == ST_IDLE) || (r_state == ST_HDR1))
        else $error("final byte pending while frame still running");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PAY |-> r_cnt <= CNT_W'(PAY_BYTES - 1))
        else $error("payload byte count out of range");
`endif

endmodule
